FILE: design/vac_pkg.sv
// Package for the vertex add and clip status block: types, codes and class helpers.
`timescale 1ns / 1ps
package vac_pkg;

    localparam int VERTEX_SLOTS_DEF = 16;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 36;

    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_CLASS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_SELECT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_MIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_MAX     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_USER_CLIP0_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_USER_CLIP0_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_USER_CLIP1_MIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_USER_CLIP1_MAX = 3'd7;

    localparam logic [4:0] CLS_08 = 5'h08;
    localparam logic [4:0] CLS_0C = 5'h0c;
    localparam logic [4:0] CLS_0E = 5'h0e;
    localparam logic [4:0] CLS_10 = 5'h10;
    localparam logic [4:0] CLS_12 = 5'h12;
    localparam logic [4:0] CLS_14 = 5'h14;
    localparam logic [4:0] CLS_15 = 5'h15;
    localparam logic [4:0] CLS_17 = 5'h17;
    localparam logic [4:0] CLS_18 = 5'h18;

    localparam logic [17:0] MASK_X      = 18'h007ff;
    localparam logic [17:0] MASK_Y      = 18'h03fff;
    localparam logic [17:0] MASK_Y_WIDE = 18'h07fff;
    localparam logic [31:0] SAT_POS     = 32'h7fffffff;
    localparam logic [31:0] SAT_NEG     = 32'h80000000;

    typedef struct packed {
        logic [4:0]  object_class;
        logic [9:0]  clip_select;
        logic [31:0] canvas_min;
        logic [31:0] canvas_max;
        logic [35:0] user_clip0_min;
        logic [35:0] user_clip0_max;
        logic [35:0] user_clip1_min;
        logic [35:0] user_clip1_max;
    } t_cfg;

    typedef struct packed {
        logic        axis;
        logic [3:0]  slot;
        logic [31:0] low;
        logic        carry;
        logic        sign_a;
        logic        sign_b;
        logic        set1_off;
        logic        no_status;
    } t_s1;

    typedef struct packed {
        logic        axis;
        logic [3:0]  slot;
        logic [31:0] sat;
        logic        carry;
        logic        oob;
        logic [3:0]  status;
        logic        no_status;
    } t_s2;

    function automatic logic user_set1_class(input logic [4:0] cls);
        return (cls == CLS_0C) || (cls == CLS_0E) || (cls == CLS_15);
    endfunction

    function automatic logic flag_class(input logic [4:0] cls);
        return ((cls >= CLS_08) && (cls <= CLS_0C)) || (cls == CLS_0E) ||
               ((cls >= CLS_10) && (cls <= CLS_12)) || (cls == CLS_14) ||
               (cls == CLS_15);
    endfunction

    function automatic logic pair_status_class(input logic [4:0] cls);
        return (cls == CLS_08) || (cls == CLS_18);
    endfunction

endpackage

FILE: design/vac_add_stage.sv
// First pipeline stage: three-way 33-bit add of the addends.
`timescale 1ns / 1ps
module vac_add_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_axis,
    input  logic [3:0]        i_vertex_index,
    input  logic [31:0]       i_addend_a,
    input  logic [31:0]       i_addend_b,
    input  logic [31:0]       i_addend_c,
    input  logic              i_canvas_only_clip,
    input  logic              i_no_status,
    output logic              o_valid,
    input  logic              i_ready,
    output vac_pkg::t_s1      o_s1
);

    logic         r_valid;
    vac_pkg::t_s1 r_s1;
    vac_pkg::t_s1 n_s1;
    logic [32:0]  sum;

    assign o_ready = !r_valid || i_ready;
    assign sum     = {1'b0, i_addend_a} + {1'b0, i_addend_b} + {1'b0, i_addend_c};

    always_comb begin
        n_s1.axis      = i_axis;
        n_s1.slot      = i_vertex_index;
        n_s1.low       = sum[31:0];
        n_s1.carry     = sum[32];
        n_s1.sign_a    = i_addend_a[31];
        n_s1.sign_b    = i_addend_b[31];
        n_s1.set1_off  = i_canvas_only_clip;
        n_s1.no_status = i_no_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

FILE: design/vac_clip_stage.sv
// Second pipeline stage: saturation, range flag, clip bounds and clip compare.
`timescale 1ns / 1ps
module vac_clip_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  vac_pkg::t_s1      i_s1,
    input  vac_pkg::t_cfg     i_cfg,
    output logic              o_valid,
    input  logic              i_ready,
    output vac_pkg::t_s2      o_s2
);

    logic         r_valid;
    vac_pkg::t_s2 r_s2;
    vac_pkg::t_s2 n_s2;
    logic         set1_cls;
    logic         use0;
    logic         use1;
    logic [1:0]   sel0;
    logic [1:0]   sel1;
    logic [17:0]  mn;
    logic [17:0]  mx;
    logic [17:0]  mask;
    logic [17:0]  coord;
    logic signed [18:0] c_s;
    logic signed [18:0] mn_s;
    logic signed [18:0] mx_s;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        set1_cls = vac_pkg::user_set1_class(i_cfg.object_class);
        use0     = i_cfg.clip_select[0] && !set1_cls;
        use1     = set1_cls && !i_s1.set1_off;
        sel0     = i_s1.axis ? i_cfg.clip_select[5:4] : i_cfg.clip_select[3:2];
        sel1     = i_s1.axis ? i_cfg.clip_select[9:8] : i_cfg.clip_select[7:6];

        mn = i_s1.axis ? {2'b00, i_cfg.canvas_min[31:16]} : {2'b00, i_cfg.canvas_min[15:0]};
        mx = i_s1.axis ? {2'b00, i_cfg.canvas_max[31:16]} : {2'b00, i_cfg.canvas_max[15:0]};
        if (sel0[0] && use0) begin
            mn = i_s1.axis ? i_cfg.user_clip0_min[35:18] : i_cfg.user_clip0_min[17:0];
        end
        if (sel0[1] && use0) begin
            mx = i_s1.axis ? i_cfg.user_clip0_max[35:18] : i_cfg.user_clip0_max[17:0];
        end
        if (sel1[0] && use1) begin
            mn = i_s1.axis ? i_cfg.user_clip1_min[35:18] : i_cfg.user_clip1_min[17:0];
        end
        if (sel1[1] && use1) begin
            mx = i_s1.axis ? i_cfg.user_clip1_max[35:18] : i_cfg.user_clip1_max[17:0];
        end

        if (!i_s1.axis) begin
            mask = vac_pkg::MASK_X;
        end else if (i_cfg.clip_select[1]) begin
            mask = vac_pkg::MASK_Y_WIDE;
        end else begin
            mask = vac_pkg::MASK_Y;
        end

        if (i_cfg.object_class == vac_pkg::CLS_17) begin
            coord = {{6{i_s1.low[15]}}, i_s1.low[15:4]};
        end else begin
            coord = i_s1.low[17:0];
        end
        c_s  = $signed({coord[17], coord});
        mn_s = $signed({1'b0, mn & mask});
        mx_s = $signed({1'b0, mx & mask});

        n_s2.axis      = i_s1.axis;
        n_s2.slot      = i_s1.slot;
        n_s2.carry     = i_s1.carry;
        n_s2.no_status = i_s1.no_status;
        n_s2.oob       = !((i_s1.low[31:15] == 17'h00000) || (i_s1.low[31:15] == 17'h1ffff));
        if ((i_s1.sign_a == i_s1.sign_b) && (i_s1.sign_a != i_s1.low[31])) begin
            n_s2.sat = i_s1.sign_a ? vac_pkg::SAT_NEG : vac_pkg::SAT_POS;
        end else begin
            n_s2.sat = i_s1.low;
        end
        n_s2.status = {c_s == mx_s, c_s > mx_s, c_s == mn_s, c_s < mn_s};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

FILE: design/vac_state.sv
// Vertex store and per-axis carry, range and clip status registers.
`timescale 1ns / 1ps
module vac_state #(
    parameter int VERTEX_SLOTS = vac_pkg::VERTEX_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  vac_pkg::t_s2      i_s2,
    input  logic [4:0]        i_object_class
);

    localparam int DEPTH = 2 * VERTEX_SLOTS;
    localparam int AW    = $clog2(DEPTH);

    logic [31:0] r_store [DEPTH];
    logic [31:0] r_status_words [4];
    logic [7:0]  r_flags [2];
    logic [4:0]  addr;
    logic        slot_ok;
    logic        wr_flags;
    logic        range_bit;
    logic [1:0]  fb;
    logic [1:0]  wi;
    logic [2:0]  nib;

    assign addr      = {i_s2.slot, i_s2.axis};
    assign slot_ok   = {28'd0, i_s2.slot} < 32'(VERTEX_SLOTS);
    assign wr_flags  = vac_pkg::flag_class(i_object_class);
    assign range_bit = (i_object_class == vac_pkg::CLS_15) ? 1'b0 : i_s2.oob;
    assign fb        = i_s2.slot[1:0];
    assign wi        = {i_s2.axis, i_s2.slot[3]};
    assign nib       = i_s2.slot[2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_store[i] <= '0;
            end
        end else if (i_we && slot_ok) begin
            r_store[addr[AW-1:0]] <= i_s2.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_status_words[i] <= '0;
            end
            r_flags[0] <= '0;
            r_flags[1] <= '0;
        end else if (i_we && !i_s2.no_status) begin
            if (wr_flags) begin
                r_flags[i_s2.axis][{1'b0, fb}]  <= i_s2.carry;
                r_flags[i_s2.axis][{1'b1, fb}]  <= range_bit;
            end
            if (vac_pkg::pair_status_class(i_object_class)) begin
                r_status_words[{i_s2.axis, 1'b0}][7:0] <= {i_s2.status, i_s2.status};
            end else begin
                r_status_words[wi][nib*4 +: 4] <= i_s2.status;
            end
        end
    end

endmodule

FILE: design/vertex_add_clip_status.sv
// Top level: configuration registers, pipeline stages and output register.
//
//   channel   direction  handshake                     payload
//   input     in         i_in_valid / o_in_ready       axis, index, addends, clip, no_status
//   output    out        o_out_valid / i_out_ready     stored value, carry, range, status
//   config    in         i_cfg_we (no wait)            i_cfg_index, i_cfg_data
//
// Three register stages (add, clip compare, output); one transaction per cycle
// sustained while the output is not stalled. The three-way add sets the first stage depth.
// Synchronous active-low reset empties the pipeline and clears config and status.
// A stall at the output backs up stage by stage without loss or repeat.
`timescale 1ns / 1ps
module vertex_add_clip_status #(
    parameter int VERTEX_SLOTS = vac_pkg::VERTEX_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vac_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vac_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_axis,
    input  logic [3:0]                    i_vertex_index,
    input  logic [31:0]                   i_addend_a,
    input  logic [31:0]                   i_addend_b,
    input  logic [31:0]                   i_addend_c,
    input  logic                          i_canvas_only_clip,
    input  logic                          i_no_status,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [31:0]                   o_stored_value,
    output logic                          o_carry_out,
    output logic                          o_out_of_range,
    output logic [3:0]                    o_clip_status
);

    vac_pkg::t_cfg r_cfg;
    vac_pkg::t_s1  s1;
    vac_pkg::t_s2  s2;
    vac_pkg::t_s2  r_out;
    logic          s1_valid;
    logic          s1_ready;
    logic          s2_valid;
    logic          s2_ready;
    logic          r_out_valid;
    logic          out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vac_pkg::REG_OBJECT_CLASS:   r_cfg.object_class   <= i_cfg_data[4:0];
                vac_pkg::REG_CLIP_SELECT:    r_cfg.clip_select    <= i_cfg_data[9:0];
                vac_pkg::REG_CANVAS_MIN:     r_cfg.canvas_min     <= i_cfg_data[31:0];
                vac_pkg::REG_CANVAS_MAX:     r_cfg.canvas_max     <= i_cfg_data[31:0];
                vac_pkg::REG_USER_CLIP0_MIN: r_cfg.user_clip0_min <= i_cfg_data;
                vac_pkg::REG_USER_CLIP0_MAX: r_cfg.user_clip0_max <= i_cfg_data;
                vac_pkg::REG_USER_CLIP1_MIN: r_cfg.user_clip1_min <= i_cfg_data;
                vac_pkg::REG_USER_CLIP1_MAX: r_cfg.user_clip1_max <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    vac_add_stage u_add (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_in_valid),
        .o_ready            (o_in_ready),
        .i_axis             (i_axis),
        .i_vertex_index     (i_vertex_index),
        .i_addend_a         (i_addend_a),
        .i_addend_b         (i_addend_b),
        .i_addend_c         (i_addend_c),
        .i_canvas_only_clip (i_canvas_only_clip),
        .i_no_status        (i_no_status),
        .o_valid            (s1_valid),
        .i_ready            (s1_ready),
        .o_s1               (s1)
    );

    vac_clip_stage u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_s1    (s1),
        .i_cfg   (r_cfg),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_s2    (s2)
    );

    assign s2_ready = !r_out_valid || i_out_ready;
    assign out_load = s2_ready && s2_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_ready) begin
            r_out_valid <= s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= s2;
        end
    end

    // state is updated once per transaction as it enters the output register
    vac_state #(
        .VERTEX_SLOTS (VERTEX_SLOTS)
    ) u_state (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_we           (out_load),
        .i_s2           (s2),
        .i_object_class (r_cfg.object_class)
    );

    assign o_out_valid    = r_out_valid;
    assign o_stored_value = r_out.sat;
    assign o_carry_out    = r_out.carry;
    assign o_out_of_range = r_out.oob;
    assign o_clip_status  = r_out.status;

endmodule
